// File: src/atcw_pkg.sv
// shared constants and types for the ansi text console writer
package atcw_pkg;

    localparam int COLUMNS = 128;
    localparam int ROWS    = 32;
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = 5;
    localparam int ADDR_W  = 12;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int CELL_W  = 16;

    localparam logic [7:0]       RST_DEFAULT_ATTR = 8'h02;
    localparam logic [ROW_W-1:0] RST_BOTTOM_ROW   = 5'd27;
    localparam logic [ROW_W-1:0] RST_SCROLL_TOP   = 5'd12;
    localparam logic [6:0]       RST_RIGHT_LIMIT  = 7'd99;
    localparam logic [ROW_W-1:0] RST_ROW_POS      = 5'd12;

    typedef struct packed {
        logic [7:0]       default_attr;
        logic [ROW_W-1:0] bottom_row;
        logic [ROW_W-1:0] scroll_top;
        logic [6:0]       right_limit;
    } t_cfg;

endpackage

// File: src/atcw_if.sv
// item channels of the console writer

interface atcw_in_if;
    import atcw_pkg::*;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [7:0]        char_byte;
    logic [ADDR_W-1:0] read_addr;

    modport source (output valid, opcode, char_byte, read_addr, input ready);
    modport sink   (input valid, opcode, char_byte, read_addr, output ready);
endinterface

interface atcw_out_if;
    import atcw_pkg::*;
    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cell_data;
    logic [7:0]        cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [7:0]        current_attr;

    modport source (output valid, cell_data, cursor_col, cursor_row, current_attr,
                    input ready);
    modport sink   (input valid, cell_data, cursor_col, cursor_row, current_attr,
                    output ready);
endinterface

// File: src/atcw_cfg.sv
// apb configuration registers of the console writer
module atcw_cfg
    import atcw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    localparam logic [1:0] REG_DEFAULT_ATTR = 2'd0;
    localparam logic [1:0] REG_BOTTOM_ROW   = 2'd1;
    localparam logic [1:0] REG_SCROLL_TOP   = 2'd2;
    localparam logic [1:0] REG_RIGHT_LIMIT  = 2'd3;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.default_attr <= RST_DEFAULT_ATTR;
            r_cfg.bottom_row   <= RST_BOTTOM_ROW;
            r_cfg.scroll_top   <= RST_SCROLL_TOP;
            r_cfg.right_limit  <= RST_RIGHT_LIMIT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DEFAULT_ATTR: r_cfg.default_attr <= pwdata[7:0];
                REG_BOTTOM_ROW:   r_cfg.bottom_row   <= pwdata[ROW_W-1:0];
                REG_SCROLL_TOP:   r_cfg.scroll_top   <= pwdata[ROW_W-1:0];
                REG_RIGHT_LIMIT:  r_cfg.right_limit  <= pwdata[6:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DEFAULT_ATTR: prdata = {24'd0, r_cfg.default_attr};
            REG_BOTTOM_ROW:   prdata = {{(32-ROW_W){1'b0}}, r_cfg.bottom_row};
            REG_SCROLL_TOP:   prdata = {{(32-ROW_W){1'b0}}, r_cfg.scroll_top};
            REG_RIGHT_LIMIT:  prdata = {25'd0, r_cfg.right_limit};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

// File: src/atcw_seq.sv
// byte parser, cursor state and sequencer around the screen cell memory
module atcw_seq
    import atcw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    atcw_in_if.sink    i_in,
    atcw_out_if.source o_out
);

    localparam logic [7:0] C_BS    = 8'h08;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_ESC   = 8'h1B;
    localparam logic [7:0] C_LBR   = 8'h5B;
    localparam logic [7:0] C_SEMI  = 8'h3B;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_NINE  = 8'h39;
    localparam logic [7:0] C_UP    = 8'h41;
    localparam logic [7:0] C_DOWN  = 8'h42;
    localparam logic [7:0] C_FWD   = 8'h43;
    localparam logic [7:0] C_BACK  = 8'h44;
    localparam logic [7:0] C_HOME  = 8'h48;
    localparam logic [7:0] C_ERASE = 8'h4A;
    localparam logic [7:0] C_SGR   = 8'h6D;
    localparam logic [7:0] TAB_END = 8'hF8;
    localparam logic [7:0] BOLD    = 8'h08;

    localparam logic [15:0] SGR_RESET   = 16'd0;
    localparam logic [15:0] SGR_BOLD    = 16'd1;
    localparam logic [15:0] SGR_NORMAL  = 16'd2;
    localparam logic [15:0] SGR_REVERSE = 16'd7;
    localparam logic [15:0] SGR_FG_LO   = 16'd30;
    localparam logic [15:0] SGR_FG_HI   = 16'd37;
    localparam logic [15:0] SGR_BG_LO   = 16'd40;
    localparam logic [15:0] SGR_BG_HI   = 16'd47;

    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [8:0]        COLS_9    = 9'(COLUMNS);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_EXEC, S_RD, S_SCR, S_SCLR, S_RESP
    } t_state;

    typedef enum logic [1:0] {
        G_RESP, G_SCROLL, G_ERASE, G_READ
    } t_go;

    // cell memory
    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rdq;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    t_state            r_state;
    logic              r_op;
    logic [7:0]        r_byte;
    logic [ADDR_W-1:0] r_addr;
    logic [7:0]        r_col;
    logic [ROW_W-1:0]  r_row;
    logic [7:0]        r_attr;
    logic              r_esc;
    logic              r_csi;
    logic [15:0]       r_param;
    logic [CELL_W-1:0] r_cell;
    logic              r_reset_pass;
    logic [ADDR_W-1:0] r_clr;
    logic [ROW_W-1:0]  r_srow;
    logic [COL_W-1:0]  r_scol;
    logic              r_issue;
    logic              r_wv;
    logic [ADDR_W-1:0] r_waddr;
    logic              r_out_valid;
    logic [CELL_W-1:0] r_out_cell;
    logic [7:0]        r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic [7:0]        r_out_attr;

    logic [7:0]        n_col;
    logic [ROW_W-1:0]  n_row;
    logic [7:0]        n_attr;
    logic              n_esc;
    logic              n_csi;
    logic [15:0]       n_param;
    t_go               n_go;
    logic              store;

    logic [15:0]       step;
    logic [19:0]       acc;
    logic [16:0]       col_sum;
    logic [16:0]       row_sum;
    logic [15:0]       sgr_lo;
    logic [15:0]       sgr_hi;
    logic [ROW_W:0]    row_inc;
    logic              out_free;
    logic              accept;

    assign i_in.ready         = (r_state == S_IDLE);
    assign accept             = i_in.valid & i_in.ready;
    assign out_free           = !r_out_valid || o_out.ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.cell_data    = r_out_cell;
    assign o_out.cursor_col   = r_out_col;
    assign o_out.cursor_row   = r_out_row;
    assign o_out.current_attr = r_out_attr;

    assign step    = (r_param == 16'd0) ? 16'd1 : r_param;
    assign acc     = 20'(r_param) * 20'd10 + 20'(r_byte - C_ZERO);
    assign col_sum = 17'(r_col) + 17'(step);
    assign row_sum = 17'(r_row) + 17'(step);
    assign sgr_lo  = r_param - SGR_FG_LO;
    assign sgr_hi  = r_param - SGR_BG_LO;
    assign row_inc = {1'b0, r_row} + 1'b1;

    // effect of one item: a console byte or a cell read
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_attr  = r_attr;
        n_esc   = r_esc;
        n_csi   = r_csi;
        n_param = r_param;
        n_go    = G_RESP;
        store   = 1'b0;
        if (r_op) begin
            n_go = G_READ;
        end else if (r_csi) begin
            if (r_byte >= C_ZERO && r_byte <= C_NINE) begin
                n_param = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];
            end else if (r_byte == C_SEMI) begin
                n_param = 16'd0;
            end else begin
                n_csi = 1'b0;
                unique case (r_byte)
                    C_UP:    n_row = (16'(r_row) > step) ? r_row - step[ROW_W-1:0]
                                                         : '0;
                    C_DOWN:  n_row = (row_sum > 17'(i_cfg.bottom_row)) ? i_cfg.bottom_row
                                                                       : row_sum[ROW_W-1:0];
                    C_FWD:   n_col = (col_sum > 17'(i_cfg.right_limit))
                                     ? {1'b0, i_cfg.right_limit} : col_sum[7:0];
                    C_BACK:  n_col = (16'(r_col) > step) ? r_col - step[7:0] : 8'd0;
                    C_HOME: begin
                        n_col = 8'd0;
                        n_row = '0;
                    end
                    C_ERASE: n_go = G_ERASE;
                    C_SGR: begin
                        priority if (r_param == SGR_RESET)
                            n_attr = i_cfg.default_attr;
                        else if (r_param == SGR_BOLD)
                            n_attr = r_attr | BOLD;
                        else if (r_param == SGR_NORMAL)
                            n_attr = r_attr & ~BOLD;
                        else if (r_param == SGR_REVERSE)
                            n_attr = {r_attr[3:0], r_attr[7:4]};
                        else if (r_param >= SGR_FG_LO && r_param <= SGR_FG_HI)
                            n_attr = {r_attr[7:4], sgr_lo[3:0]};
                        else if (r_param >= SGR_BG_LO && r_param <= SGR_BG_HI)
                            n_attr = {sgr_hi[3:0], r_attr[3:0]};
                        else
                            n_attr = r_attr;
                    end
                    default: n_csi = 1'b0;
                endcase
            end
        end else if (r_esc) begin
            n_esc = (r_byte == C_ESC);
            n_csi = (r_byte == C_LBR);
            if (r_byte == C_LBR) begin
                n_param = 16'd0;
            end
        end else begin
            unique case (r_byte)
                C_BS:  n_col = (r_col != 8'd0) ? r_col - 8'd1 : r_col;
                C_TAB: n_col = (r_col < TAB_END) ? ((r_col + 8'd8) & TAB_END) : r_col;
                C_LF: begin
                    if (row_inc > {1'b0, i_cfg.bottom_row}) begin
                        n_row = i_cfg.bottom_row;
                        n_go  = G_SCROLL;
                    end else begin
                        n_row = row_inc[ROW_W-1:0];
                    end
                end
                C_CR:  n_col = 8'd0;
                C_ESC: n_esc = 1'b1;
                default: begin
                    if ({1'b0, r_col} < COLS_9) begin
                        store = 1'b1;
                        n_col = r_col + 8'd1;
                    end
                end
            endcase
        end
    end

    // memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_waddr;
        mem_wdata = r_rdq;
        mem_raddr = r_addr;
        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            S_EXEC: begin
                mem_we    = store && (32'(r_row) < ROWS);
                mem_waddr = {r_row, r_col[COL_W-1:0]};
                mem_wdata = {r_attr, r_byte};
            end
            S_SCR: begin
                mem_we    = r_wv;
                mem_raddr = {r_srow + 1'b1, r_scol};
            end
            S_SCLR: begin
                mem_we    = 1'b1;
                mem_waddr = {i_cfg.bottom_row, r_scol};
                mem_wdata = '0;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdq <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_col        <= 8'd0;
            r_row        <= RST_ROW_POS;
            r_attr       <= RST_DEFAULT_ATTR;
            r_esc        <= 1'b0;
            r_csi        <= 1'b0;
            r_param      <= 16'd0;
            r_reset_pass <= 1'b1;
            r_clr        <= '0;
            r_issue      <= 1'b0;
            r_wv         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && r_state != S_RESP) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST_CELL) begin
                        r_state      <= r_reset_pass ? S_IDLE : S_RESP;
                        r_reset_pass <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= i_in.opcode;
                        r_byte  <= i_in.char_byte;
                        r_addr  <= i_in.read_addr;
                        r_cell  <= '0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_col   <= n_col;
                    r_row   <= n_row;
                    r_attr  <= n_attr;
                    r_esc   <= n_esc;
                    r_csi   <= n_csi;
                    r_param <= n_param;
                    r_scol  <= '0;
                    r_wv    <= 1'b0;
                    r_clr   <= '0;
                    unique case (n_go)
                        G_RESP:  r_state <= S_RESP;
                        G_READ:  r_state <= S_RD;
                        G_ERASE: r_state <= S_CLR;
                        G_SCROLL: begin
                            r_srow  <= i_cfg.scroll_top;
                            r_issue <= 1'b1;
                            r_state <= (i_cfg.scroll_top < i_cfg.bottom_row) ? S_SCR
                                                                             : S_SCLR;
                        end
                        default: r_state <= S_RESP;
                    endcase
                end
                S_RD: begin
                    r_cell  <= r_rdq;
                    r_state <= S_RESP;
                end
                S_SCR: begin
                    if (r_issue) begin
                        r_wv    <= 1'b1;
                        r_waddr <= {r_srow, r_scol};
                        r_scol  <= r_scol + 1'b1;
                        if (r_scol == LAST_COL) begin
                            if (r_srow + 1'b1 == i_cfg.bottom_row) begin
                                r_issue <= 1'b0;
                            end else begin
                                r_srow <= r_srow + 1'b1;
                            end
                        end
                    end else begin
                        r_wv    <= 1'b0;
                        r_scol  <= '0;
                        r_state <= S_SCLR;
                    end
                end
                S_SCLR: begin
                    r_scol <= r_scol + 1'b1;
                    if (r_scol == LAST_COL) begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_cell  <= r_cell;
                        r_out_col   <= r_col;
                        r_out_row   <= r_row;
                        r_out_attr  <= r_attr;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: src/ansi_text_console_writer_unit.sv
// top level of the ansi text console writer
// a console byte passes the execute and respond states before its result is registered, a cell read also the read state
// a line feed that scrolls first moves each row of the scroll region up by one, then clears the bottom row
// an erase display sequence clears all 4096 cells, one cell cleared per cycle
// a new item is taken only in the idle state, so not before the result of the last one has been registered
// reset: a clearing pass runs through all 4096 cells of the memory before the first item
module ansi_text_console_writer_unit
    import atcw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    atcw_in_if.sink     i_in,
    atcw_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg cfg;

    atcw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    atcw_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

// File: verif/atcw_checker.sv
// console codes shared by the bench and the checker that predicts and compares each result item
`timescale 1ns / 1ps

package atcw_tb_pkg;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_CSI  = 8'h5B;
    localparam logic [7:0] CH_SEP  = 8'h3B;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [7:0] FIN_UP    = 8'h41;
    localparam logic [7:0] FIN_DOWN  = 8'h42;
    localparam logic [7:0] FIN_RIGHT = 8'h43;
    localparam logic [7:0] FIN_LEFT  = 8'h44;
    localparam logic [7:0] FIN_HOME  = 8'h48;
    localparam logic [7:0] FIN_ERASE = 8'h4A;
    localparam logic [7:0] FIN_SGR   = 8'h6D;

    localparam int SGR_RESET   = 0;
    localparam int SGR_BOLD    = 1;
    localparam int SGR_NORMAL  = 2;
    localparam int SGR_REVERSE = 7;
    localparam int SGR_FG      = 30;
    localparam int SGR_BG      = 40;
    localparam int SGR_SPAN    = 7;

    localparam int         PARAM_MAX = 65535;
    localparam logic [7:0] TAB_LIMIT = 8'hF8;
    localparam logic [7:0] ATTR_BOLD = 8'h08;

endpackage

module atcw_checker
    import atcw_pkg::*, atcw_tb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    atcw_in_if   i_in,
    atcw_out_if  i_out,
    input  t_cfg i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [CELL_W-1:0] cell_val;
        logic [7:0]        col;
        logic [ROW_W-1:0]  row;
        logic [7:0]        attr;
    } t_console_status;

    logic [CELL_W-1:0] screen [CELLS];
    logic [7:0]        col_now;
    logic [ROW_W-1:0]  row_now;
    logic [7:0]        attr_now;
    logic              esc_pending;
    logic              csi_open;
    int                csi_value;
    int                fail_count = 0;
    t_console_status   status_q [$];

    assign o_fail_count = fail_count;
    initial o_pending = 0;

    task automatic report(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want) begin
            report($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    task automatic erase_screen();
        for (int i = 0; i < CELLS; i++) begin
            screen[i] = '0;
        end
    endtask

    task automatic scroll_region();
        int r;
        int c;
        for (r = int'(i_cfg.scroll_top); r < int'(i_cfg.bottom_row); r++) begin
            if (r + 1 < ROWS) begin
                for (c = 0; c < COLUMNS; c++) begin
                    screen[r * COLUMNS + c] = screen[(r + 1) * COLUMNS + c];
                end
            end
        end
        if (int'(i_cfg.bottom_row) < ROWS) begin
            for (c = 0; c < COLUMNS; c++) begin
                screen[int'(i_cfg.bottom_row) * COLUMNS + c] = '0;
            end
        end
    endtask

    task automatic finish_csi(input logic [7:0] c);
        int step;
        int pos;
        step = (csi_value != 0) ? csi_value : 1;
        case (c)
            FIN_UP: begin
                pos = int'(row_now);
                row_now = ROW_W'((pos > step) ? pos - step : 0);
            end
            FIN_DOWN: begin
                pos = int'(row_now) + step;
                row_now = (pos > int'(i_cfg.bottom_row)) ? i_cfg.bottom_row : ROW_W'(pos);
            end
            FIN_RIGHT: begin
                pos = int'(col_now) + step;
                col_now = (pos > int'(i_cfg.right_limit)) ? {1'b0, i_cfg.right_limit}
                                                          : 8'(pos);
            end
            FIN_LEFT: begin
                pos = int'(col_now);
                col_now = 8'((pos > step) ? pos - step : 0);
            end
            FIN_HOME: begin
                col_now = '0;
                row_now = '0;
            end
            FIN_ERASE: begin
                erase_screen();
            end
            FIN_SGR: begin
                if (csi_value == SGR_RESET) attr_now = i_cfg.default_attr;
                else if (csi_value == SGR_BOLD) attr_now = attr_now | ATTR_BOLD;
                else if (csi_value == SGR_NORMAL) attr_now = attr_now & ~ATTR_BOLD;
                else if (csi_value == SGR_REVERSE) attr_now = {attr_now[3:0], attr_now[7:4]};
                else if (csi_value >= SGR_FG && csi_value <= SGR_FG + SGR_SPAN)
                    attr_now[3:0] = 4'(csi_value - SGR_FG);
                else if (csi_value >= SGR_BG && csi_value <= SGR_BG + SGR_SPAN)
                    attr_now[7:4] = 4'(csi_value - SGR_BG);
            end
            default: ;
        endcase
        csi_open = 1'b0;
    endtask

    task automatic apply_byte(input logic [7:0] c);
        int acc;
        if (csi_open) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                acc = csi_value * 10 + int'(c - CH_ZERO);
                csi_value = (acc > PARAM_MAX) ? PARAM_MAX : acc;
            end else if (c == CH_SEP) begin
                csi_value = 0;
            end else begin
                finish_csi(c);
            end
        end else if (esc_pending) begin
            esc_pending = (c == CH_ESC);
            csi_open = (c == CH_CSI);
            if (csi_open) csi_value = 0;
        end else begin
            case (c)
                CH_BS: begin
                    if (col_now != 8'd0) col_now = col_now - 8'd1;
                end
                CH_TAB: begin
                    if (col_now < TAB_LIMIT) col_now = (col_now + 8'd8) & TAB_LIMIT;
                end
                CH_LF: begin
                    if (int'(row_now) + 1 > int'(i_cfg.bottom_row)) begin
                        scroll_region();
                        row_now = i_cfg.bottom_row;
                    end else begin
                        row_now = row_now + 5'd1;
                    end
                end
                CH_CR: begin
                    col_now = '0;
                end
                CH_ESC: begin
                    esc_pending = 1'b1;
                end
                default: begin
                    if (int'(col_now) < COLUMNS) begin
                        if (int'(row_now) < ROWS)
                            screen[int'(row_now) * COLUMNS + int'(col_now)] = {attr_now, c};
                        col_now = col_now + 8'd1;
                    end
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        t_console_status want;
        t_console_status got;
        if (!i_rst_n) begin
            erase_screen();
            col_now = '0;
            row_now = RST_ROW_POS;
            attr_now = RST_DEFAULT_ATTR;
            esc_pending = 1'b0;
            csi_open = 1'b0;
            csi_value = 0;
            status_q.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                want.cell_val = '0;
                if (i_in.opcode == OP_READ) begin
                    if (int'(i_in.read_addr) < CELLS) want.cell_val = screen[i_in.read_addr];
                end else begin
                    apply_byte(i_in.char_byte);
                end
                want.col = col_now;
                want.row = row_now;
                want.attr = attr_now;
                status_q.push_back(want);
            end
            if (i_out.valid && i_out.ready) begin
                got.cell_val = i_out.cell_data;
                got.col = i_out.cursor_col;
                got.row = i_out.cursor_row;
                got.attr = i_out.current_attr;
                if (status_q.size() == 0) begin
                    report($sformatf("result with no item waiting, cell %0h col %0d row %0d",
                                     got.cell_val, got.col, got.row));
                end else begin
                    want = status_q.pop_front();
                    compare_field("cell_data", got.cell_val, want.cell_val);
                    compare_field("cursor_col", 16'(got.col), 16'(want.col));
                    compare_field("cursor_row", 16'(got.row), 16'(want.row));
                    compare_field("current_attr", 16'(got.attr), 16'(want.attr));
                end
            end
        end
        o_pending <= status_q.size();
    end

endmodule

// File: verif/ansi_text_console_writer_unit_tb.sv
// bench top for the console writer: clock, reset, register writes, item stimulus and verdict
`timescale 1ns / 1ps

module ansi_text_console_writer_unit_tb;
    import atcw_pkg::*;
    import atcw_tb_pkg::*;

    localparam logic [3:0] REG_DEFAULT_ATTR = 4'h0;
    localparam logic [3:0] REG_BOTTOM_ROW   = 4'h4;
    localparam logic [3:0] REG_SCROLL_TOP   = 4'h8;
    localparam logic [3:0] REG_RIGHT_LIMIT  = 4'hC;

    localparam int IDLE_LIMIT      = 20000;
    localparam int DRAIN_CYCLES    = 4200;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 210;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    t_cfg cfg_shadow;
    int   fail_count;
    int   pending;
    int   item_count  = 0;
    int   idle_cycles = 0;
    bit   stall_on    = 1'b0;

    atcw_in_if  in_ch ();
    atcw_out_if out_ch ();

    always #5 i_clk = ~i_clk;

    ansi_text_console_writer_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    atcw_checker u_status_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_shadow),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // result side
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            gap = stall_on ? $urandom_range(0, 3) : 0;
            if (gap != 0) begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            @(negedge i_clk);
        end
    end

    task automatic send_item(input logic op, input logic [7:0] ch,
                             input logic [ADDR_W-1:0] addr);
        int gap;
        gap = stall_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.opcode = op;
        in_ch.char_byte = ch;
        in_ch.read_addr = addr;
        in_ch.valid = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        item_count++;
    endtask

    task automatic send_byte(input logic [7:0] ch);
        send_item(OP_BYTE, ch, ADDR_W'($urandom_range(0, CELLS - 1)));
    endtask

    task automatic send_read(input logic [ADDR_W-1:0] addr);
        send_item(OP_READ, 8'($urandom_range(0, 255)), addr);
    endtask

    task automatic send_number(input int value);
        string digits;
        digits = $sformatf("%0d", value);
        for (int i = 0; i < digits.len(); i++) begin
            send_byte(digits[i]);
        end
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [3:0] addr, input logic [31:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic apply_config(input t_cfg c);
        drain();
        write_reg(REG_DEFAULT_ATTR, {24'd0, c.default_attr});
        write_reg(REG_BOTTOM_ROW, {27'd0, c.bottom_row});
        write_reg(REG_SCROLL_TOP, {27'd0, c.scroll_top});
        write_reg(REG_RIGHT_LIMIT, {25'd0, c.right_limit});
        cfg_shadow = c;
    endtask

    task automatic send_random_burst();
        int         sel;
        int         fsel;
        int         nparam;
        int         value;
        logic [7:0] fin;
        logic [7:0] ch;
        logic [6:0] col;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            repeat ($urandom_range(1, 8)) begin
                if ($urandom_range(0, 3) != 0) ch = 8'($urandom_range(8'h20, 8'h7E));
                else ch = 8'($urandom_range(0, 255));
                send_byte(ch);
            end
        end else if (sel < 47) begin
            case ($urandom_range(0, 4))
                0: send_byte(CH_BS);
                1: send_byte(CH_TAB);
                2: send_byte(CH_CR);
                3: send_byte(CH_LF);
                default: begin
                    send_byte(CH_CR);
                    send_byte(CH_LF);
                end
            endcase
        end else if (sel < 72) begin
            fsel = $urandom_range(0, 99);
            if (fsel < 14) fin = FIN_UP;
            else if (fsel < 28) fin = FIN_DOWN;
            else if (fsel < 42) fin = FIN_RIGHT;
            else if (fsel < 56) fin = FIN_LEFT;
            else if (fsel < 63) fin = FIN_HOME;
            else if (fsel < 67) fin = FIN_ERASE;
            else if (fsel < 92) fin = FIN_SGR;
            else begin
                do fin = 8'($urandom_range(0, 255));
                while ((fin >= CH_ZERO && fin <= CH_NINE) || fin == CH_SEP);
            end
            send_byte(CH_ESC);
            send_byte(CH_CSI);
            nparam = $urandom_range(0, 2);
            for (int k = 0; k < nparam; k++) begin
                if (k != 0) send_byte(CH_SEP);
                if (fin == FIN_SGR && k == nparam - 1) begin
                    case ($urandom_range(0, 6))
                        0: value = SGR_RESET;
                        1: value = SGR_BOLD;
                        2: value = SGR_NORMAL;
                        3: value = SGR_REVERSE;
                        4: value = SGR_FG + int'($urandom_range(0, SGR_SPAN));
                        5: value = SGR_BG + int'($urandom_range(0, SGR_SPAN));
                        default: value = int'($urandom_range(0, 99));
                    endcase
                end else begin
                    case ($urandom_range(0, 9))
                        0: value = int'($urandom_range(100000, 999999));
                        1, 2: value = int'($urandom_range(10, 140));
                        default: value = int'($urandom_range(0, 9));
                    endcase
                end
                if ($urandom_range(0, 7) != 0) send_number(value);
            end
            send_byte(fin);
        end else if (sel < 80) begin
            case ($urandom_range(0, 2))
                0: begin
                    send_byte(CH_ESC);
                    send_byte(8'($urandom_range(0, 255)));
                end
                1: begin
                    send_byte(CH_ESC);
                    send_byte(CH_ESC);
                    send_byte(CH_CSI);
                    send_number(int'($urandom_range(0, 47)));
                    send_byte(FIN_SGR);
                end
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end else begin
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 4) < 3) col = 7'($urandom_range(0, 15));
                else col = 7'($urandom_range(0, COLUMNS - 1));
                send_read({5'($urandom_range(0, ROWS - 1)), col});
            end
        end
    endtask

    initial begin
        t_cfg phase_cfg;
        int   start;
        bit   flipped;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_BYTE;
        in_ch.char_byte = '0;
        in_ch.read_addr = '0;
        cfg_shadow = {RST_DEFAULT_ATTR, RST_BOTTOM_ROW, RST_SCROLL_TOP, RST_RIGHT_LIMIT};
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed items at reset settings
        send_read('0);
        send_byte(8'h5A);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(CH_BS);
        send_byte(CH_TAB);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_read({RST_ROW_POS, 7'd0});
        send_byte(CH_ESC);
        send_byte(CH_CSI);
        send_number(65536);
        send_byte(FIN_DOWN);
        send_byte(CH_ESC);
        send_byte(CH_ESC);
        send_byte(CH_CSI);
        send_number(SGR_BOLD);
        send_byte(FIN_SGR);
        send_byte(CH_ESC);
        send_byte(8'h51);
        send_byte(CH_ESC);
        send_byte(CH_CSI);
        send_byte(FIN_ERASE);
        send_read(ADDR_W'(CELLS - 1));

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: phase_cfg = cfg_shadow;
                1: phase_cfg = {8'hFF, 5'd31, 5'd0, 7'd127};
                2: phase_cfg = {8'h00, 5'd1, 5'd30, 7'd0};
                3: phase_cfg = {8'h5A, 5'd21, 5'd17, 7'd64};
                default: begin
                    phase_cfg.default_attr = 8'($urandom_range(0, 255));
                    phase_cfg.bottom_row = ROW_W'($urandom_range(1, 31));
                    phase_cfg.scroll_top = ROW_W'($urandom_range(0, 30));
                    phase_cfg.right_limit = 7'($urandom_range(0, 127));
                end
            endcase
            if (phase != 0) apply_config(phase_cfg);
            stall_on = (phase % 2 == 0);
            flipped = 1'b0;
            start = item_count;
            while (item_count - start < ITEMS_PER_PHASE) begin
                if (!flipped && item_count - start >= ITEMS_PER_PHASE / 2) begin
                    flipped = 1'b1;
                    stall_on = !stall_on;
                    if (phase == 3) drain();
                end
                send_random_burst();
            end
        end

        in_ch.valid = 1'b0;
        drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
